FILE: hw/rtl/stc_pkg.sv
// ---------------------------------------------------------------------------
// stc_pkg: shared types and constants
// Status codes, sizes and controller interface structs for the run table.
// ---------------------------------------------------------------------------
package stc_pkg;

	localparam int MAX_RUNS = 256;
	localparam int IDX_W    = $clog2(MAX_RUNS);
	localparam int CNT_W    = $clog2(MAX_RUNS + 1);
	localparam int RUN_W    = 96;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_SAMPLE_ZERO = 3'd1;
	localparam logic [2:0] ST_FULL        = 3'd2;
	localparam logic [2:0] ST_EMPTY       = 3'd3;
	localparam logic [2:0] ST_ZERO_SPC    = 3'd4;

	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE, S_APP_RD, S_APP_WAIT, S_APP_DO,
		S_LK_INIT, S_LK_RD, S_LK_WAIT, S_LK_MUL, S_LK_TEST,
		S_DIV, S_FINISH, S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture input beat
		logic rd_last;    // read entry run_count-1
		logic app_do;     // evaluate append
		logic lk_init;    // choose start run
		logic rd_cur;     // read entry i and i+1
		logic mul;        // form run length
		logic test;       // boundary test / advance
		logic div_start;
		logic finish;     // build lookup result
		logic out_take;   // result beat accepted
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_lookup;
		logic early_done; // result already formed
		logic hit;
		logic div_busy;
	} sts_t;

endpackage

FILE: hw/rtl/sample_to_chunk_table_lookup_top.sv
// ---------------------------------------------------------------------------
// sample_to_chunk_table_lookup_top: sample-to-chunk run table
// Appends runs and locates the chunk holding a sample.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | command, first_chunk, chunk_samples,
//          |                      | desc_index, sample_number
//  out     | out_valid / out_stall| status, merged, chunk_number,
//          |                      | found_desc_index, chunk_first_sample
//
// One beat at a time. An append steps from the idle state that takes the beat
// through read, wait and apply to the result state. A lookup reads, waits,
// multiplies and tests for each run walked, then runs the serial divider (one
// bit a cycle); an early error skips the walk and the divider.
// Run RAM has no reset; count and cache clear on arst_n.
// The result beat holds while out_stall is high; no input is taken meanwhile.
module sample_to_chunk_table_lookup_top import stc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [31:0] first_chunk,
	input  logic [31:0] chunk_samples,
	input  logic [31:0] desc_index,
	input  logic [31:0] sample_number,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        merged,
	output logic [31:0] chunk_number,
	output logic [31:0] found_desc_index,
	output logic [31:0] chunk_first_sample
);

	cmd_t cmd;
	sts_t sts;

	stc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	stc_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.command            (command),
		.first_chunk        (first_chunk),
		.chunk_samples      (chunk_samples),
		.desc_index         (desc_index),
		.sample_number      (sample_number),
		.status             (status),
		.merged             (merged),
		.chunk_number       (chunk_number),
		.found_desc_index   (found_desc_index),
		.chunk_first_sample (chunk_first_sample)
	);

endmodule

FILE: hw/rtl/stc_ram.sv
// ---------------------------------------------------------------------------
// stc_ram: generic single-write, dual-read RAM
// Registered read data on both ports.
// ---------------------------------------------------------------------------
module stc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: hw/rtl/stc_div.sv
// ---------------------------------------------------------------------------
// stc_div: 32-bit restoring divider
// One quotient bit per cycle; divisor assumed nonzero.
// ---------------------------------------------------------------------------
module stc_div import stc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quot
);

	logic [5:0]  cnt_q;
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dsr_q;
	logic [32:0] trial;

	assign trial = {rem_q[31:0], quo_q[31]} - {1'b0, dsr_q};
	assign busy  = (cnt_q != 6'd0);
	assign quot  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 33'd0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

endmodule

FILE: hw/rtl/stc_ctrl.sv
// ---------------------------------------------------------------------------
// stc_ctrl: command sequencer
// Steps append and lookup walks; drives datapath commands.
// ---------------------------------------------------------------------------
module stc_ctrl import stc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_APP_RD;
				end
			end
			S_APP_RD: begin
				if (sts.is_lookup) begin
					state_d = S_LK_INIT;
				end else begin
					cmd.rd_last = 1'b1;
					state_d     = S_APP_WAIT;
				end
			end
			// keep the last-entry address so read data survives into S_APP_DO
			S_APP_WAIT: begin
				cmd.rd_last = 1'b1;
				state_d     = S_APP_DO;
			end
			S_APP_DO: begin
				cmd.app_do = 1'b1;
				state_d    = S_OUT;
			end
			S_LK_INIT: begin
				cmd.lk_init = 1'b1;
				state_d     = S_LK_RD;
			end
			S_LK_RD: begin
				if (sts.early_done) begin
					state_d = S_OUT;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d    = S_LK_WAIT;
				end
			end
			S_LK_WAIT: state_d = S_LK_MUL;
			S_LK_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_LK_TEST;
			end
			S_LK_TEST: begin
				cmd.test = 1'b1;
				if (sts.hit)
					state_d = S_DIV;
				else
					state_d = S_LK_RD;
			end
			S_DIV: begin
				if (sts.early_done) begin
					state_d = S_OUT;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!sts.div_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_OUT;
				end
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					cmd.out_take = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: hw/rtl/stc_dp.sv
// ---------------------------------------------------------------------------
// stc_dp: run table datapath
// Run RAM, run count, cache, walk registers, multiplier and divider.
// ---------------------------------------------------------------------------
module stc_dp import stc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        command,
	input  logic [31:0] first_chunk,
	input  logic [31:0] chunk_samples,
	input  logic [31:0] desc_index,
	input  logic [31:0] sample_number,
	output logic [2:0]  status,
	output logic        merged,
	output logic [31:0] chunk_number,
	output logic [31:0] found_desc_index,
	output logic [31:0] chunk_first_sample
);

	logic             cmd_q;
	logic [31:0]      fc_q, spc_q, di_q, smp_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] cache_run_q;
	logic [31:0]      cache_fs_q;
	logic [CNT_W-1:0] idx_q;
	logic [31:0]      start_q, len_q, off_q;
	logic             done_q, hit_q;

	logic             we;
	logic [IDX_W-1:0] raddr_a, raddr_b;
	logic [RUN_W-1:0] rdata_a, rdata_b;
	logic [31:0]      cur_fc, cur_spc, cur_di, nxt_fc;
	logic [31:0]      quot, qmul;
	logic             div_busy;
	logic [CNT_W-1:0] last_idx;
	logic             is_last;

	assign last_idx = count_q - CNT_W'(1);
	assign cur_fc   = rdata_a[95:64];
	assign cur_spc  = rdata_a[63:32];
	assign cur_di   = rdata_a[31:0];
	assign nxt_fc   = rdata_b[95:64];
	assign is_last  = (idx_q == last_idx);

	always_comb begin
		raddr_a = idx_q[IDX_W-1:0];
		raddr_b = idx_q[IDX_W-1:0] + IDX_W'(1);
		if (cmd.rd_last)
			raddr_a = last_idx[IDX_W-1:0];
	end

	assign we = cmd.app_do && !(count_q != '0 && cur_spc == spc_q && cur_di == di_q)
		&& (count_q < CNT_W'(MAX_RUNS));

	stc_ram #(.WIDTH(RUN_W), .DEPTH(MAX_RUNS)) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (count_q[IDX_W-1:0]),
		.wdata   ({fc_q, spc_q, di_q}),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	stc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (off_q),
		.divisor  (cur_spc),
		.busy     (div_busy),
		.quot     (quot)
	);

	assign qmul = quot * cur_spc;

	always_comb begin
		sts.is_lookup  = (cmd_q == CMD_LOOKUP);
		sts.early_done = done_q;
		sts.hit        = is_last || (smp_q < start_q + len_q);
		sts.div_busy   = div_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cache_run_q <= '0;
			cache_fs_q  <= 32'd0;
		end else begin
			if (we)
				count_q <= count_q + CNT_W'(1);
			if (cmd.finish) begin
				cache_run_q <= idx_q[IDX_W-1:0];
				cache_fs_q  <= start_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			fc_q  <= first_chunk;
			spc_q <= chunk_samples;
			di_q  <= desc_index;
			smp_q <= sample_number;
			done_q <= 1'b0;
			status <= ST_OK;
			merged <= 1'b0;
			chunk_number       <= 32'd0;
			found_desc_index   <= 32'd0;
			chunk_first_sample <= 32'd0;
		end
		if (cmd.app_do) begin
			if (count_q != '0 && cur_spc == spc_q && cur_di == di_q)
				merged <= 1'b1;
			else if (count_q >= CNT_W'(MAX_RUNS))
				status <= ST_FULL;
		end
		if (cmd.lk_init) begin
			if (smp_q == 32'd0) begin
				status <= ST_SAMPLE_ZERO;
				done_q <= 1'b1;
			end else if (count_q == '0) begin
				status <= ST_EMPTY;
				done_q <= 1'b1;
			end
			if (cache_fs_q != 32'd0 && cache_fs_q < smp_q
				&& CNT_W'(cache_run_q) < count_q) begin
				idx_q   <= CNT_W'(cache_run_q);
				start_q <= cache_fs_q;
			end else begin
				idx_q   <= '0;
				start_q <= 32'd1;
			end
		end
		if (cmd.mul)
			len_q <= 32'(nxt_fc - cur_fc) * cur_spc;
		if (cmd.test) begin
			hit_q <= sts.hit;
			if (sts.hit) begin
				off_q <= smp_q - start_q;
				if (cur_spc == 32'd0) begin
					status <= ST_ZERO_SPC;
					done_q <= 1'b1;
				end
			end else begin
				start_q <= start_q + len_q;
				idx_q   <= idx_q + CNT_W'(1);
			end
		end
		if (cmd.finish && hit_q) begin
			chunk_number       <= cur_fc + quot;
			found_desc_index   <= cur_di;
			chunk_first_sample <= qmul + start_q;
		end
	end

endmodule
